>>> src/ldd_pkg.sv
// Package for the light dip detector: widths, register and command codes,
// and the structs passed between the detector's modules. No dependencies.
package ldd_pkg;

  localparam int SAMPLE_BITS   = 12;
  localparam int FRAC_BITS     = 16;
  localparam int AVG_W         = SAMPLE_BITS + FRAC_BITS;
  localparam int HISTORY_DEPTH = 1024;
  localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
  localparam int LEN_W         = 11;
  localparam int RECENCY_W     = 10;
  localparam int SHIFT_W       = 5;
  localparam int THR_W         = 12;
  localparam int DIP_W         = 16;
  localparam int SEEN_W        = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 12;

  localparam logic [SHIFT_W-1:0] SHIFT_MIN   = SHIFT_W'(1);
  localparam logic [SHIFT_W-1:0] SHIFT_MAX   = SHIFT_W'(16);
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(10);
  localparam logic [THR_W-1:0]   DROP_RESET  = THR_W'(228);
  localparam logic [THR_W-1:0]   REARM_RESET = THR_W'(159);
  localparam logic [LEN_W-1:0]   LEN_MAX     = LEN_W'(HISTORY_DEPTH);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHIFT  = 2'd0,
    CFG_DROP   = 2'd1,
    CFG_REARM  = 2'd2,
    CFG_LENGTH = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    CMD_SAMPLE = 1'b0,
    CMD_READ   = 1'b1
  } cmd_t;

  typedef struct packed {
    logic                   wr;
    logic                   rd;
    logic [RECENCY_W-1:0]   recency;
    logic [SAMPLE_BITS-1:0] wdata;
  } ring_req_t;

  typedef struct packed {
    logic             read_ok;
    logic [LEN_W-1:0] fill;
  } ring_rsp_t;

  typedef struct packed {
    logic [AVG_W-1:0]       avg;
    logic                   in_dip;
    logic                   started;
    logic [SAMPLE_BITS-1:0] stored;
  } ema_res_t;

endpackage

>>> src/ldd_in_if.sv
// Request channel into the light dip detector: valid, ready and one request.
// Depends on ldd_pkg for the field widths.
interface ldd_in_if import ldd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   cmd;
  logic [SAMPLE_BITS-1:0] sample;
  logic [RECENCY_W-1:0]   recency;

  modport source (output valid, cmd, sample, recency, input ready);
  modport sink (input valid, cmd, sample, recency, output ready);
endinterface

>>> src/ldd_out_if.sv
// Result channel out of the light dip detector: valid, ready and one result.
// Depends on ldd_pkg for the field widths.
interface ldd_out_if import ldd_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [AVG_W-1:0]       average;
  logic                   in_dip;
  logic                   dip_started;
  logic [DIP_W-1:0]       dip_total;
  logic [SEEN_W-1:0]      samples_seen;
  logic [LEN_W-1:0]       history_fill;
  logic [SAMPLE_BITS-1:0] history_value;
  logic                   read_ok;

  modport source (output valid, average, in_dip, dip_started, dip_total, samples_seen,
                  history_fill, history_value, read_ok, input ready);
  modport sink (input valid, average, in_dip, dip_started, dip_total, samples_seen,
                history_fill, history_value, read_ok, output ready);
endinterface

>>> src/ldd_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ldd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> src/ldd_ema.sv
// Moving average update and dip onset and re-arm decision for one sample.
// Depends on ldd_pkg.
module ldd_ema import ldd_pkg::*; (
  input  logic [AVG_W-1:0]       avg,
  input  logic                   dip_active,
  input  logic [SAMPLE_BITS-1:0] sample,
  input  logic [SHIFT_W-1:0]     shift,
  input  logic [THR_W-1:0]       dip_drop,
  input  logic [THR_W-1:0]       rearm_rise,
  output ema_res_t               res
);

  logic [AVG_W-1:0] target;
  logic [AVG_W-1:0] diff_up;
  logic [AVG_W-1:0] diff_dn;
  logic [AVG_W:0]   round_add;
  logic [AVG_W:0]   step_dn;
  logic [AVG_W-1:0] avg_nxt;
  logic [AVG_W:0]   drop_sum;
  logic [AVG_W:0]   rearm_sum;
  logic             drop_hit;
  logic             rearm_hit;

  assign target    = {sample, {FRAC_BITS{1'b0}}};
  assign diff_up   = target - avg;
  assign diff_dn   = avg - target;
  assign round_add = ((AVG_W + 1)'(1) << shift) - (AVG_W + 1)'(1);
  assign step_dn   = ({1'b0, diff_dn} + round_add) >> shift;

  always_comb begin
    if (target >= avg) begin
      avg_nxt = avg + (diff_up >> shift);
    end else begin
      avg_nxt = avg - step_dn[AVG_W-1:0];
    end
  end

  assign drop_sum  = {1'b0, target} + {1'b0, dip_drop, {FRAC_BITS{1'b0}}};
  assign rearm_sum = {1'b0, avg_nxt} + {1'b0, rearm_rise, {FRAC_BITS{1'b0}}};
  assign drop_hit  = drop_sum <= {1'b0, avg_nxt};
  assign rearm_hit = {1'b0, target} > rearm_sum;

  always_comb begin
    res.avg     = avg_nxt;
    res.started = !dip_active && drop_hit;
    res.in_dip  = dip_active;
    res.stored  = sample;
    if (res.started) begin
      res.in_dip = 1'b1;
      res.stored = avg_nxt[AVG_W-1:FRAC_BITS];
    end else if (dip_active && rearm_hit) begin
      res.in_dip = 1'b0;
    end
  end

endmodule

>>> src/ldd_ring.sv
// History ring: write slot, fill level, read address arithmetic and the RAM.
// Depends on ldd_pkg and ldd_ram.
module ldd_ring import ldd_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   clear,
  input  logic [LEN_W-1:0]       len,
  input  ring_req_t              req,
  output ring_rsp_t              rsp,
  output logic [SAMPLE_BITS-1:0] rd_data
);

  logic [ADDR_W-1:0] slot_r;
  logic [ADDR_W-1:0] slot_nxt;
  logic [LEN_W-1:0]  fill_r;
  logic [LEN_W-1:0]  fill_nxt;
  logic [LEN_W-1:0]  slot_inc;
  logic [LEN_W:0]    back;
  logic [LEN_W:0]    idx;
  logic              read_ok;

  assign slot_inc = {{(LEN_W - ADDR_W){1'b0}}, slot_r} + LEN_W'(1);
  assign slot_nxt = (slot_inc >= len) ? '0 : slot_inc[ADDR_W-1:0];
  assign fill_nxt = (req.wr && fill_r < len) ? fill_r + LEN_W'(1) : fill_r;
  assign read_ok  = req.rd && ({{(LEN_W - RECENCY_W){1'b0}}, req.recency} < fill_r);

  assign back = {{(LEN_W + 1 - ADDR_W){1'b0}}, slot_r} + {1'b0, len} - (LEN_W + 1)'(1)
              - {{(LEN_W + 1 - RECENCY_W){1'b0}}, req.recency};
  assign idx  = (back >= {1'b0, len}) ? back - {1'b0, len} : back;

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      slot_r <= '0;
      fill_r <= '0;
    end else if (req.wr) begin
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
    end
  end

  assign rsp.read_ok = read_ok;
  assign rsp.fill    = fill_nxt;

  ldd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (HISTORY_DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (req.wr),
    .wr_addr (slot_r),
    .wr_data (req.wdata),
    .rd_en   (read_ok),
    .rd_addr (idx[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

endmodule

>>> src/light_dip_detector_with_history_unit.sv
// Light dip detector top level: configuration registers, request pipeline and counters.
// Throughput is one request per cycle while the result channel is not stalled,
// set by the combinational average update and the history RAM's single write port
// and single registered read port.
// Reset clears the average, dip state, counters, write slot and fill level at once.
// Depends on ldd_pkg, ldd_in_if, ldd_out_if, ldd_ema and ldd_ring.
module light_dip_detector_with_history_unit import ldd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  ldd_in_if.sink                in_ch,
  ldd_out_if.source             out_ch
);

  logic [SHIFT_W-1:0] shift_r;
  logic [THR_W-1:0]   drop_r;
  logic [THR_W-1:0]   rearm_r;
  logic [LEN_W-1:0]   len_r;
  logic [SHIFT_W-1:0] shift_nxt;
  logic [LEN_W-1:0]   len_nxt;
  logic               len_wr;

  logic [AVG_W-1:0]  avg_r;
  logic              dip_r;
  logic [DIP_W-1:0]  dip_cnt_r;
  logic [SEEN_W-1:0] seen_r;
  logic [DIP_W-1:0]  dip_cnt_nxt;
  logic [SEEN_W-1:0] seen_nxt;

  logic                   s1_valid_r;
  logic                   s1_cmd_r;
  logic [SAMPLE_BITS-1:0] s1_sample_r;
  logic [RECENCY_W-1:0]   s1_recency_r;

  logic              s2_valid_r;
  logic [AVG_W-1:0]  s2_avg_r;
  logic              s2_in_dip_r;
  logic              s2_started_r;
  logic [DIP_W-1:0]  s2_dip_cnt_r;
  logic [SEEN_W-1:0] s2_seen_r;
  logic [LEN_W-1:0]  s2_fill_r;
  logic              s2_read_ok_r;

  logic                   out_valid_r;
  logic [AVG_W-1:0]       out_avg_r;
  logic                   out_in_dip_r;
  logic                   out_started_r;
  logic [DIP_W-1:0]       out_dip_cnt_r;
  logic [SEEN_W-1:0]      out_seen_r;
  logic [LEN_W-1:0]       out_fill_r;
  logic [SAMPLE_BITS-1:0] out_value_r;
  logic                   out_read_ok_r;

  logic                   en_out;
  logic                   en_s2;
  logic                   en_s1;
  logic                   step;
  logic                   is_sample;
  logic                   started;
  ema_res_t               ema;
  ring_req_t              ring_req;
  ring_rsp_t              ring_rsp;
  logic [SAMPLE_BITS-1:0] ring_rd_data;

  always_comb begin
    if (cfg_wdata[SHIFT_W-1:0] < SHIFT_MIN) begin
      shift_nxt = SHIFT_MIN;
    end else if (cfg_wdata[SHIFT_W-1:0] > SHIFT_MAX) begin
      shift_nxt = SHIFT_MAX;
    end else begin
      shift_nxt = cfg_wdata[SHIFT_W-1:0];
    end
    if (cfg_wdata[LEN_W-1:0] == '0) begin
      len_nxt = LEN_W'(1);
    end else if (cfg_wdata[LEN_W-1:0] > LEN_MAX) begin
      len_nxt = LEN_MAX;
    end else begin
      len_nxt = cfg_wdata[LEN_W-1:0];
    end
  end

  assign len_wr = cfg_wr_en && (cfg_index == CFG_LENGTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= SHIFT_RESET;
      drop_r  <= DROP_RESET;
      rearm_r <= REARM_RESET;
      len_r   <= LEN_MAX;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_SHIFT:  shift_r <= shift_nxt;
        CFG_DROP:   drop_r  <= cfg_wdata[THR_W-1:0];
        CFG_REARM:  rearm_r <= cfg_wdata[THR_W-1:0];
        CFG_LENGTH: len_r   <= len_nxt;
        default:    shift_r <= shift_r;
      endcase
    end
  end

  assign en_out      = !out_valid_r || out_ch.ready;
  assign en_s2       = !s2_valid_r || en_out;
  assign en_s1       = !s1_valid_r || en_s2;
  assign in_ch.ready = en_s1;

  assign step      = s1_valid_r && en_s2;
  assign is_sample = (s1_cmd_r == CMD_SAMPLE);

  ldd_ema u_ema (
    .avg        (avg_r),
    .dip_active (dip_r),
    .sample     (s1_sample_r),
    .shift      (shift_r),
    .dip_drop   (drop_r),
    .rearm_rise (rearm_r),
    .res        (ema)
  );

  assign started     = is_sample && ema.started;
  assign dip_cnt_nxt = (started && dip_cnt_r != '1) ? dip_cnt_r + DIP_W'(1) : dip_cnt_r;
  assign seen_nxt    = (is_sample && seen_r != '1) ? seen_r + SEEN_W'(1) : seen_r;

  always_comb begin
    ring_req.wr      = step && is_sample;
    ring_req.rd      = step && !is_sample;
    ring_req.recency = s1_recency_r;
    ring_req.wdata   = ema.stored;
  end

  ldd_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .clear   (len_wr),
    .len     (len_r),
    .req     (ring_req),
    .rsp     (ring_rsp),
    .rd_data (ring_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_r     <= '0;
      dip_r     <= 1'b0;
      dip_cnt_r <= '0;
      seen_r    <= '0;
    end else if (step && is_sample) begin
      avg_r     <= ema.avg;
      dip_r     <= ema.in_dip;
      dip_cnt_r <= dip_cnt_nxt;
      seen_r    <= seen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_s1) begin
        s1_valid_r <= in_ch.valid;
      end
      if (en_s2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (en_out) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_cmd_r     <= in_ch.cmd;
      s1_sample_r  <= in_ch.sample;
      s1_recency_r <= in_ch.recency;
    end
    if (en_s2) begin
      s2_avg_r     <= is_sample ? ema.avg : avg_r;
      s2_in_dip_r  <= is_sample ? ema.in_dip : dip_r;
      s2_started_r <= started;
      s2_dip_cnt_r <= dip_cnt_nxt;
      s2_seen_r    <= seen_nxt;
      s2_fill_r    <= ring_rsp.fill;
      s2_read_ok_r <= ring_rsp.read_ok;
    end
    if (en_out) begin
      out_avg_r     <= s2_avg_r;
      out_in_dip_r  <= s2_in_dip_r;
      out_started_r <= s2_started_r;
      out_dip_cnt_r <= s2_dip_cnt_r;
      out_seen_r    <= s2_seen_r;
      out_fill_r    <= s2_fill_r;
      out_value_r   <= s2_read_ok_r ? ring_rd_data : '0;
      out_read_ok_r <= s2_read_ok_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.average       = out_avg_r;
  assign out_ch.in_dip        = out_in_dip_r;
  assign out_ch.dip_started   = out_started_r;
  assign out_ch.dip_total     = out_dip_cnt_r;
  assign out_ch.samples_seen  = out_seen_r;
  assign out_ch.history_fill  = out_fill_r;
  assign out_ch.history_value = out_value_r;
  assign out_ch.read_ok       = out_read_ok_r;

endmodule

>>> src/ldd_checker.sv
// Port-level checks for the light dip detector, bound to its top level.
// Depends on ldd_pkg and light_dip_detector_with_history_unit.
module ldd_checker import ldd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [AVG_W-1:0]       out_average,
  input logic                   out_in_dip,
  input logic                   out_dip_started,
  input logic [SEEN_W-1:0]      out_samples_seen,
  input logic [SAMPLE_BITS-1:0] out_history_value,
  input logic                   out_read_ok
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average)
      && $stable(out_samples_seen))
    else $error("Stalled result changed or was dropped.");

  a_start_in_dip: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_dip_started |-> out_in_dip)
    else $error("A dip onset was reported without an active dip.");

  a_read_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_read_ok |-> !out_dip_started)
    else $error("A history read reported a dip onset.");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_read_ok |-> out_history_value == '0)
    else $error("History value is nonzero without a successful read.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid right after reset.");

endmodule

bind light_dip_detector_with_history_unit ldd_checker u_ldd_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_average       (out_ch.average),
  .out_in_dip        (out_ch.in_dip),
  .out_dip_started   (out_ch.dip_started),
  .out_samples_seen  (out_ch.samples_seen),
  .out_history_value (out_ch.history_value),
  .out_read_ok       (out_ch.read_ok)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for light_dip_detector_with_history_unit: directed and random
// requests with random idling, checked field by field against an in-bench predictor.
// Depends on ldd_pkg, ldd_in_if, ldd_out_if and the detector RTL.
module tb_top;
  import ldd_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES      = 10;
  localparam int PER_PHASE   = 70;

  typedef struct packed {
    logic [AVG_W-1:0]       average;
    logic                   in_dip;
    logic                   dip_started;
    logic [DIP_W-1:0]       dip_total;
    logic [SEEN_W-1:0]      samples_seen;
    logic [LEN_W-1:0]       history_fill;
    logic [SAMPLE_BITS-1:0] history_value;
    logic                   read_ok;
  } readout_t;

  typedef struct {
    bit                     is_write;
    cfg_reg_t               reg_idx;
    logic [CFG_DATA_W-1:0]  data;
    cmd_t                   cmd;
    logic [SAMPLE_BITS-1:0] smp;
    logic [RECENCY_W-1:0]   recency;
    bit                     typed;
    readout_t               want;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  ldd_in_if in_ch ();
  ldd_out_if out_ch ();

  light_dip_detector_with_history_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #10 clk = ~clk;

  // Predictor copy of the registers and state.
  logic [SHIFT_W-1:0]     p_shift;
  logic [THR_W-1:0]       p_drop;
  logic [THR_W-1:0]       p_rearm;
  logic [LEN_W-1:0]       p_length;
  logic [AVG_W-1:0]       p_avg;
  logic                   p_dip;
  logic [DIP_W-1:0]       p_dips;
  logic [SEEN_W-1:0]      p_seen;
  int unsigned            p_slot;
  int unsigned            p_fill;
  logic [SAMPLE_BITS-1:0] p_ring [HISTORY_DEPTH];

  readout_t  due_readouts [$];
  step_row_t plan [$];

  int errors;
  int results_checked;
  int cycles;
  int stall_left;
  bit steady;
  int sample_reqs;
  int read_reqs;
  int dips_begun;
  int history_hits;
  int settings_used;
  int level;
  int dip_left;
  bit overshoot;

  int shift_plan  [PHASES] = '{1, 16, 0, 31, 2, 10, 4, 20, 3, 8};
  int length_plan [PHASES] = '{1, 5, 16, 0, 2047, 3, 64, 1024, 9, 40};

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] clamp_reading(int v);
    if (v < 0) begin
      return '0;
    end else if (v > 4095) begin
      return '1;
    end
    return SAMPLE_BITS'(v);
  endfunction

  function automatic readout_t fixed_readout(logic [AVG_W-1:0] avg, int seen, int fill,
                                             int value, bit ok);
    readout_t o;
    o = '0;
    o.average = avg;
    o.samples_seen = SEEN_W'(seen);
    o.history_fill = LEN_W'(fill);
    o.history_value = SAMPLE_BITS'(value);
    o.read_ok = ok;
    return o;
  endfunction

  task automatic detector_next(input cmd_t c, input logic [SAMPLE_BITS-1:0] s,
                               input logic [RECENCY_W-1:0] r, output readout_t o);
    int unsigned len;
    int unsigned k;
    int unsigned idx;
    logic [AVG_W:0] tgt;
    logic [AVG_W:0] diff;
    logic [AVG_W:0] round_up;
    logic [SAMPLE_BITS-1:0] stored;
    len = (p_length == 0) ? 1 : (p_length > HISTORY_DEPTH) ? HISTORY_DEPTH : p_length;
    k = (p_shift < SHIFT_MIN) ? SHIFT_MIN : (p_shift > SHIFT_MAX) ? SHIFT_MAX : p_shift;
    if (p_slot >= len) p_slot = 0;
    if (p_fill > len) p_fill = len;
    o = '0;
    if (c == CMD_SAMPLE) begin
      sample_reqs++;
      tgt = {1'b0, s, {FRAC_BITS{1'b0}}};
      stored = s;
      if (tgt >= {1'b0, p_avg}) begin
        diff = tgt - {1'b0, p_avg};
        p_avg = p_avg + AVG_W'(diff >> k);
      end else begin
        diff = {1'b0, p_avg} - tgt;
        round_up = ((AVG_W+1)'(1) << k) - (AVG_W+1)'(1);
        p_avg = p_avg - AVG_W'((diff + round_up) >> k);
      end
      if (!p_dip && tgt + {1'b0, p_drop, {FRAC_BITS{1'b0}}} <= {1'b0, p_avg}) begin
        p_dip = 1'b1;
        o.dip_started = 1'b1;
        stored = p_avg[AVG_W-1:FRAC_BITS];
        if (p_dips != '1) p_dips++;
        dips_begun++;
      end else if (p_dip && tgt > {1'b0, p_avg} + {1'b0, p_rearm, {FRAC_BITS{1'b0}}}) begin
        p_dip = 1'b0;
      end
      p_ring[p_slot] = stored;
      p_slot = (p_slot + 1 >= len) ? 0 : p_slot + 1;
      if (p_fill < len) p_fill++;
      if (p_seen != '1) p_seen++;
    end else begin
      read_reqs++;
      if (r < p_fill) begin
        idx = (p_slot + len - 1 - r) % len;
        o.history_value = p_ring[idx];
        o.read_ok = 1'b1;
        history_hits++;
      end
    end
    o.average = p_avg;
    o.in_dip = p_dip;
    o.dip_total = p_dips;
    o.samples_seen = p_seen;
    o.history_fill = LEN_W'(p_fill);
  endtask

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] exp);
    errors++;
    if (errors <= 40) begin
      $display("mismatch on result %0d: %s is %0h, expected %0h", results_checked, field,
               got, exp);
    end
  endtask

  task automatic check_result();
    readout_t exp;
    if (due_readouts.size() == 0) begin
      report_mismatch("unexpected result", 1, 0);
      return;
    end
    exp = due_readouts.pop_front();
    if (out_ch.average !== exp.average)
      report_mismatch("average", out_ch.average, exp.average);
    if (out_ch.in_dip !== exp.in_dip)
      report_mismatch("in_dip", out_ch.in_dip, exp.in_dip);
    if (out_ch.dip_started !== exp.dip_started)
      report_mismatch("dip_started", out_ch.dip_started, exp.dip_started);
    if (out_ch.dip_total !== exp.dip_total)
      report_mismatch("dip_total", out_ch.dip_total, exp.dip_total);
    if (out_ch.samples_seen !== exp.samples_seen)
      report_mismatch("samples_seen", out_ch.samples_seen, exp.samples_seen);
    if (out_ch.history_fill !== exp.history_fill)
      report_mismatch("history_fill", out_ch.history_fill, exp.history_fill);
    if (out_ch.history_value !== exp.history_value)
      report_mismatch("history_value", out_ch.history_value, exp.history_value);
    if (out_ch.read_ok !== exp.read_ok)
      report_mismatch("read_ok", out_ch.read_ok, exp.read_ok);
    results_checked++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) check_result();
  end

  always @(posedge clk) begin
    if (steady) begin
      stall_left = 0;
      out_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      stall_left = ($urandom_range(0, 5) == 0) ? pick_gap() : 0;
      out_ch.ready <= (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_request(input cmd_t c, input logic [SAMPLE_BITS-1:0] s,
                              input logic [RECENCY_W-1:0] r, input bit typed,
                              input readout_t want);
    readout_t o;
    int gap;
    in_ch.valid <= 1'b1;
    in_ch.cmd <= c;
    in_ch.sample <= s;
    in_ch.recency <= r;
    do @(posedge clk); while (!in_ch.ready);
    detector_next(c, s, r, o);
    due_readouts.push_back(typed ? want : o);
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Every request yields a result, so an empty queue means the pipeline has drained.
  task automatic settle_block();
    in_ch.valid <= 1'b0;
    while (due_readouts.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_SHIFT: p_shift = data[SHIFT_W-1:0];
      CFG_DROP:  p_drop = data[THR_W-1:0];
      CFG_REARM: p_rearm = data[THR_W-1:0];
      CFG_LENGTH: begin
        p_length = data[LEN_W-1:0];
        p_fill = 0;
        p_slot = 0;
      end
      default: ;
    endcase
    settings_used++;
  endtask

  task automatic add_write(input cfg_reg_t idx, input int data);
    step_row_t row;
    row = '{default: '0, reg_idx: idx, cmd: CMD_SAMPLE};
    row.is_write = 1'b1;
    row.data = CFG_DATA_W'(data);
    plan.push_back(row);
  endtask

  task automatic add_req(input cmd_t c, input int s, input int r, input bit typed,
                         input readout_t want);
    step_row_t row;
    row = '{default: '0, reg_idx: CFG_SHIFT, cmd: c};
    row.smp = SAMPLE_BITS'(s);
    row.recency = RECENCY_W'(r);
    row.typed = typed;
    row.want = want;
    plan.push_back(row);
  endtask

  // Random requests: mostly a drifting light level with well-formed dips and
  // recoveries, plus reads of the history and some unshaped noise.
  task automatic random_request(output cmd_t c, output logic [SAMPLE_BITS-1:0] s,
                                output logic [RECENCY_W-1:0] r);
    int pick;
    int avg_int;
    int v;
    pick = $urandom_range(0, 99);
    avg_int = int'(p_avg[AVG_W-1:FRAC_BITS]);
    c = CMD_SAMPLE;
    s = SAMPLE_BITS'($urandom_range(0, 4095));
    r = RECENCY_W'($urandom_range(0, 1023));
    if (pick < 25) begin
      c = CMD_READ;
      if ($urandom_range(0, 3) != 0) begin
        r = RECENCY_W'($urandom_range(0, (p_fill < 1022) ? p_fill + 1 : 1023));
      end
    end else if (pick < 35) begin
      s = s;
    end else if (dip_left > 0) begin
      if ($urandom_range(0, 4) == 0) begin
        v = avg_int - int'(p_drop) + int'($urandom_range(1, 3));
      end else begin
        v = avg_int - int'(p_drop) - int'($urandom_range(0, 200));
      end
      s = clamp_reading(v);
      dip_left--;
      if (dip_left == 0) overshoot = 1'b1;
    end else if (overshoot) begin
      if ($urandom_range(0, 4) == 0) begin
        v = avg_int + int'(p_rearm) - int'($urandom_range(0, 3));
      end else begin
        v = avg_int + int'(p_rearm) + int'($urandom_range(1, 200));
      end
      s = clamp_reading(v);
      overshoot = 1'b0;
    end else begin
      level = level + int'($urandom_range(0, 30)) - 15;
      if (level < 0) level = 0;
      if (level > 4095) level = 4095;
      s = clamp_reading(level + int'($urandom_range(0, 40)) - 20);
      if ($urandom_range(0, 9) == 0) dip_left = $urandom_range(1, 5);
    end
  endtask

  initial begin
    step_row_t row;
    cmd_t c;
    logic [SAMPLE_BITS-1:0] s;
    logic [RECENCY_W-1:0] r;
    int drop_val;
    int rearm_val;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_SHIFT;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SAMPLE;
    in_ch.sample = '0;
    in_ch.recency = '0;
    out_ch.ready = 1'b0;
    steady = 1'b0;
    stall_left = 0;
    p_shift = SHIFT_RESET;
    p_drop = DROP_RESET;
    p_rearm = REARM_RESET;
    p_length = LEN_MAX;
    p_avg = '0;
    p_dip = 1'b0;
    p_dips = '0;
    p_seen = '0;
    p_slot = 0;
    p_fill = 0;
    for (int i = 0; i < HISTORY_DEPTH; i++) p_ring[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty history after reset, then the two extreme readings.
    add_req(CMD_READ, 0, 0, 1, fixed_readout(0, 0, 0, 0, 0));
    add_req(CMD_READ, 4095, 1023, 1, fixed_readout(0, 0, 0, 0, 0));
    add_req(CMD_SAMPLE, 0, 0, 1, fixed_readout(0, 1, 1, 0, 0));
    add_req(CMD_READ, 0, 0, 1, fixed_readout(0, 1, 1, 0, 1));
    add_req(CMD_SAMPLE, 4095, 1023, 1, fixed_readout(262080, 2, 2, 0, 0));
    add_req(CMD_READ, 0, 0, 0, '0);
    add_req(CMD_READ, 0, 1, 0, '0);
    add_req(CMD_READ, 0, 2, 1, fixed_readout(262080, 2, 2, 0, 0));
    // Fast average, then a dip onset that stores the average, a hold and a re-arm.
    add_write(CFG_SHIFT, 1);
    repeat (4) add_req(CMD_SAMPLE, 4095, 0, 0, '0);
    add_req(CMD_SAMPLE, 0, 0, 0, '0);
    add_req(CMD_READ, 0, 0, 0, '0);
    add_req(CMD_SAMPLE, 0, 0, 0, '0);
    add_req(CMD_SAMPLE, 4095, 0, 0, '0);
    // Shift below and above its range.
    add_write(CFG_SHIFT, 0);
    add_req(CMD_SAMPLE, 4095, 0, 0, '0);
    add_write(CFG_SHIFT, 31);
    add_req(CMD_SAMPLE, 0, 0, 0, '0);
    add_write(CFG_DROP, 0);
    add_write(CFG_REARM, 4095);
    add_write(CFG_SHIFT, 16);
    add_req(CMD_SAMPLE, 0, 0, 0, '0);
    add_req(CMD_SAMPLE, 4095, 0, 0, '0);
    // A zero length acts as one entry and empties the history.
    add_write(CFG_LENGTH, 0);
    add_req(CMD_READ, 0, 0, 0, '0);
    add_req(CMD_SAMPLE, 100, 0, 0, '0);
    add_req(CMD_SAMPLE, 200, 0, 0, '0);
    add_req(CMD_READ, 0, 0, 0, '0);
    add_req(CMD_READ, 0, 1, 0, '0);
    add_write(CFG_LENGTH, 2047);
    add_write(CFG_DROP, 4095);
    add_write(CFG_REARM, 0);
    add_write(CFG_SHIFT, 10);
    add_req(CMD_SAMPLE, 4095, 0, 0, '0);
    add_req(CMD_READ, 0, 0, 0, '0);

    foreach (plan[i]) begin
      row = plan[i];
      if (row.is_write) begin
        settle_block();
        write_register(row.reg_idx, row.data);
      end else begin
        send_request(row.cmd, row.smp, row.recency, row.typed, row.want);
      end
    end

    level = 2000;
    dip_left = 0;
    overshoot = 1'b0;
    for (int phase = 0; phase < PHASES; phase++) begin
      settle_block();
      steady = (phase % 3 == 2);
      drop_val = (phase == 1) ? 0 : (phase == 5) ? 4095 : $urandom_range(30, 400);
      rearm_val = (phase == 3) ? 0 : (phase == 7) ? 4095 : $urandom_range(0, 300);
      write_register(CFG_SHIFT, CFG_DATA_W'(shift_plan[phase]));
      write_register(CFG_DROP, CFG_DATA_W'(drop_val));
      write_register(CFG_REARM, CFG_DATA_W'(rearm_val));
      write_register(CFG_LENGTH, CFG_DATA_W'(length_plan[phase]));
      level = $urandom_range(300, 3800);
      for (int n = 0; n < PER_PHASE; n++) begin
        random_request(c, s, r);
        send_request(c, s, r, 1'b0, '0);
      end
    end

    settle_block();
    repeat (10) @(posedge clk);
    $display("Ran %0d sample and %0d read requests across %0d register writes.",
             sample_reqs, read_reqs, settings_used);
    $display("Saw %0d dip onsets and %0d history hits; %0d results checked.",
             dips_begun, history_hits, results_checked);
    if (errors == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

>>> light_dip_detector_with_history_unit.f
src/ldd_pkg.sv
src/ldd_in_if.sv
src/ldd_out_if.sv
src/ldd_ram.sv
src/ldd_ema.sv
src/ldd_ring.sv
src/light_dip_detector_with_history_unit.sv
src/ldd_checker.sv
sim/tb_top.sv
